// File: rtl/core/brf_pkg.sv
package brf_pkg;

  // Q.30 constants for the cosine path
  localparam logic [38:0] HALF_PI   = 39'd1686629713;
  localparam logic [38:0] QUART_PI  = 39'd843314856;
  localparam logic [33:0] GAIN_INV  = 34'd652032874;
  // floor(2^46 / HALF_PI), never above the true reciprocal
  localparam logic [15:0] HALF_PI_RECIP = 16'd41721;
  localparam logic [30:0] TOL_RESET = 31'd134218;
  localparam logic [2:0]  ADDR_TOL  = 3'd0;

  // result of one evaluation of f, reduced to what the bisection test needs
  typedef struct packed {
    logic done;
    logic neg;
    logic zero;
  } brf_res_t;

  function automatic logic [31:0] atan_q30(input logic [5:0] idx);
    logic [31:0] v;
    case (idx)
      6'd0:  v = 32'h3243F6A8;
      6'd1:  v = 32'h1DAC6705;
      6'd2:  v = 32'h0FADBAFC;
      6'd3:  v = 32'h07F56EA6;
      6'd4:  v = 32'h03FEAB76;
      6'd5:  v = 32'h01FFD55B;
      6'd6:  v = 32'h00FFFAAA;
      6'd7:  v = 32'h007FFF55;
      6'd8:  v = 32'h003FFFEA;
      6'd9:  v = 32'h001FFFFD;
      6'd10: v = 32'h000FFFFF;
      6'd11: v = 32'h0007FFFF;
      6'd12: v = 32'h0003FFFF;
      6'd13: v = 32'h0001FFFF;
      6'd14: v = 32'h0000FFFF;
      6'd15: v = 32'h00007FFF;
      6'd16: v = 32'h00003FFF;
      6'd17: v = 32'h00001FFF;
      6'd18: v = 32'h00000FFF;
      6'd19: v = 32'h000007FF;
      6'd20: v = 32'h000003FF;
      6'd21: v = 32'h000001FF;
      6'd22: v = 32'h000000FF;
      6'd23: v = 32'h0000007F;
      6'd24: v = 32'h0000003F;
      6'd25: v = 32'h0000001F;
      6'd26: v = 32'h0000000F;
      6'd27: v = 32'h00000008;
      6'd28: v = 32'h00000004;
      6'd29: v = 32'h00000002;
      6'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/brf_feval.sv
module brf_feval import brf_pkg::*; #(
  parameter int DATA_WIDTH    = 32,
  parameter int CORDIC_STAGES = 30
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DATA_WIDTH-1:0] x_in,
  output brf_res_t              res
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_SQ   = 3'd1;
  localparam logic [2:0] F_DIV  = 3'd2;
  localparam logic [2:0] F_ROT  = 3'd3;
  localparam logic [2:0] F_FIN  = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [31:0]        ax_r;
  logic               huge_r;
  logic [63:0]        sq_r;
  logic [38:0]        rem_r;
  logic [7:0]         k_r;
  logic [2:0]         dcnt_r;
  logic [5:0]         icnt_r;
  logic signed [33:0] cx_r, cy_r;
  logic signed [32:0] cz_r;
  brf_res_t           res_r;

  logic signed [63:0] xs;
  logic [63:0]        ax64;
  logic [38:0]        u_w, rem_sub, kq_w, kh_w;
  logic signed [33:0] dx, dy, cs;
  logic signed [32:0] ang;
  logic signed [39:0] fv;

  always_comb begin
    xs      = 64'(signed'(x_in));
    ax64    = xs[63] ? (64'd0 - xs) : xs;
    rem_sub = rem_r - HALF_PI;
    kq_w    = 39'(rem_r[38:16]) * 39'(HALF_PI_RECIP);
    kh_w    = 39'(k_r) * HALF_PI;
    u_w     = (39'(ax_r) << 5) + (39'(ax_r) << 3) + QUART_PI;
    dx      = cy_r >>> icnt_r;
    dy      = cx_r >>> icnt_r;
    ang     = signed'({1'b0, atan_q30(icnt_r)});
    case (k_r[1:0])
      2'd0:    cs = cx_r;
      2'd1:    cs = -cy_r;
      2'd2:    cs = -cx_r;
      default: cs = cy_r;
    endcase
    fv = signed'({3'b000, sq_r[63:27]}) - 40'(cs >>> 3);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE:  if (start) state_nxt = F_SQ;
      F_SQ:    state_nxt = F_DIV;
      F_DIV:   if (dcnt_r == 3'd0) state_nxt = F_ROT;
      F_ROT:   if (icnt_r == 6'(CORDIC_STAGES - 1)) state_nxt = F_FIN;
      F_FIN:   state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      res_r   <= '0;
    end else begin
      state_r    <= state_nxt;
      res_r.done <= (state_r == F_FIN);
      if (state_r == F_FIN) begin
        res_r.neg  <= !huge_r && fv[39];
        res_r.zero <= !huge_r && (fv == 40'sd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: begin
        ax_r   <= ax64[31:0];
        huge_r <= |ax64[63:32];
      end
      F_SQ: begin
        sq_r   <= 64'(ax_r) * 64'(ax_r);
        rem_r  <= u_w;
        k_r    <= '0;
        dcnt_r <= 3'd2;
      end
      F_DIV: begin
        // estimate t / (pi/2) by reciprocal, at most one low; fix it last
        case (dcnt_r)
          3'd2:    k_r <= kq_w[37:30];
          3'd1:    rem_r <= rem_r - kh_w;
          default: begin
            if (rem_r >= HALF_PI) begin
              rem_r <= rem_sub;
              k_r   <= k_r + 8'd1;
            end
          end
        endcase
        dcnt_r <= dcnt_r - 3'd1;
        if (dcnt_r == 3'd0) begin
          cx_r   <= signed'(GAIN_INV);
          cy_r   <= '0;
          icnt_r <= '0;
        end
      end
      F_ROT: begin
        if (icnt_r == 6'd0) begin
          // first stage starts from the remainder, centered on zero
          if (rem_r >= QUART_PI) begin
            cx_r <= cx_r - dx;
            cy_r <= cy_r + dy;
            cz_r <= 33'(signed'({1'b0, rem_r}) - signed'({1'b0, QUART_PI})) - ang;
          end else begin
            cx_r <= cx_r + dx;
            cy_r <= cy_r - dy;
            cz_r <= 33'(signed'({1'b0, rem_r}) - signed'({1'b0, QUART_PI})) + ang;
          end
        end else if (!cz_r[32]) begin
          cx_r <= cx_r - dx;
          cy_r <= cy_r + dy;
          cz_r <= cz_r - ang;
        end else begin
          cx_r <= cx_r + dx;
          cy_r <= cy_r - dy;
          cz_r <= cz_r + ang;
        end
        icnt_r <= icnt_r + 6'd1;
      end
      default: ;
    endcase
  end

  assign res = res_r;

endmodule

// File: rtl/core/bisection_root_finder.sv
// Channel   Direction  Transaction
// in_*      slave      tdata = {upper_end, lower_end}, one interval
// out_*     master     tdata = {limit_hit, steps_taken, root}, one result
// cfg_*     APB slave  register 0: tolerance
//
// A non-empty interval evaluates f once at lower_end and once per step taken; each
// evaluation of f runs a range reduction and CORDIC_STAGES rotations
// on the shared evaluation unit. Empty intervals skip evaluation entirely.
// rst_n is synchronous; it restores the tolerance and empties the pipeline.
// in_tready is low while an interval is in work; a stalled result holds.
module bisection_root_finder import brf_pkg::*; #(
  parameter int MAX_STEPS     = 40,
  parameter int DATA_WIDTH    = 32,
  parameter int CORDIC_STAGES = 30
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [DW-1:0] lower_end, [2DW-1:DW] upper_end, zero fill
  input  logic [((2*DATA_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [DW-1:0] root, [DW+6:DW] steps_taken, [DW+7] limit_hit, zero fill
  output logic [((DATA_WIDTH+15)/8)*8-1:0]  out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int DW    = DATA_WIDTH;
  localparam int CW    = (DW > 31) ? DW : 31;
  localparam int OUT_W = ((DW + 15) / 8) * 8;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INIT = 3'd1;
  localparam logic [2:0] S_FA   = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_FM   = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [30:0]   tol_r;
  logic [DW-1:0] a_r, b_r, m_r;
  logic          fa_neg_r, fa_zero_r, limit_r;
  logic [6:0]    steps_r;
  logic          out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  logic [DW:0]   sum_w;
  logic [DW-1:0] mid_w, width_w;
  logic          wide_w, fe_start;
  logic [DW-1:0] fe_x;
  brf_res_t      fe_res;

  always_comb begin
    sum_w   = {a_r[DW-1], a_r} + {b_r[DW-1], b_r};
    mid_w   = sum_w[DW:1];
    width_w = b_r - a_r;
    wide_w  = CW'(width_w) > CW'(tol_r);
    fe_start = ((state_r == S_INIT) && (signed'(a_r) < signed'(b_r))) ||
               ((state_r == S_CHK) && wide_w && (steps_r < 7'(MAX_STEPS)));
    fe_x     = (state_r == S_INIT) ? a_r : mid_w;
  end

  brf_feval #(.DATA_WIDTH(DW), .CORDIC_STAGES(CORDIC_STAGES)) u_feval (
    .clk   (clk),
    .rst_n (rst_n),
    .start (fe_start),
    .x_in  (fe_x),
    .res   (fe_res)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_INIT;
      S_INIT: state_nxt = fe_start ? S_FA : S_DONE;
      S_FA:   if (fe_res.done) state_nxt = S_CHK;
      S_CHK:  state_nxt = fe_start ? S_FM : S_DONE;
      S_FM:   if (fe_res.done) state_nxt = S_CHK;
      S_DONE: if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tol_r       <= TOL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == ADDR_TOL))
        tol_r <= cfg_pwdata[30:0];
      if ((state_r == S_DONE) && (!out_valid_r || out_tready))
        out_valid_r <= 1'b1;
      else if (out_tready)
        out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        a_r     <= in_tdata[DW-1:0];
        b_r     <= in_tdata[2*DW-1:DW];
        steps_r <= '0;
        limit_r <= 1'b0;
      end
      S_FA: if (fe_res.done) begin
        fa_neg_r  <= fe_res.neg;
        fa_zero_r <= fe_res.zero;
      end
      S_CHK: begin
        m_r <= mid_w;
        if (wide_w && !(steps_r < 7'(MAX_STEPS))) limit_r <= 1'b1;
      end
      S_FM: if (fe_res.done) begin
        // root lies in [a, mid] when f(a) and f(mid) do not share a strict sign
        if (fa_zero_r || fe_res.zero || (fa_neg_r != fe_res.neg)) begin
          b_r <= m_r;
        end else begin
          a_r       <= m_r;
          fa_neg_r  <= fe_res.neg;
          fa_zero_r <= fe_res.zero;
        end
        steps_r <= steps_r + 7'd1;
      end
      S_DONE: if (!out_valid_r || out_tready)
        out_data_r <= OUT_W'({limit_r, steps_r, mid_w});
      default: ;
    endcase
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_prdata = (cfg_paddr == ADDR_TOL) ? {1'b0, tol_r} : 32'd0;
  assign cfg_pready = 1'b1;

endmodule

// File: rtl/core/brf_checker.sv
module brf_checker #(
  parameter int MAX_STEPS  = 40,
  parameter int DATA_WIDTH = 32
) (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [((DATA_WIDTH+15)/8)*8-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

  a_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[DATA_WIDTH+6:DATA_WIDTH] <= 7'(MAX_STEPS))
    else $error("step count above limit");

  a_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[DATA_WIDTH+7] |->
      out_tdata[DATA_WIDTH+6:DATA_WIDTH] == 7'(MAX_STEPS))
    else $error("limit flag without full step count");

endmodule

bind bisection_root_finder brf_checker #(
  .MAX_STEPS(MAX_STEPS),
  .DATA_WIDTH(DATA_WIDTH)
) u_brf_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import brf_pkg::*;

  localparam int          DW         = 32;
  localparam longint      HALF_PI_Q  = 64'sd1686629713;
  localparam longint      GAIN_Q     = 64'sd652032874;
  localparam int          N_STAGES   = 30;
  localparam int          STEP_LIMIT = 40;
  localparam logic [2:0]  ADDR_SPARE = 3'd4;
  localparam int          CYCLE_CAP  = 6000000;
  localparam int          ONE_Q27    = 134217728;

  localparam longint ATAN_TAB [0:29] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
    64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002
  };

  typedef struct {
    logic signed [DW-1:0] root;
    logic [6:0]           steps;
    logic                 limit;
  } search_res_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;     // [31:0] lower_end, [63:32] upper_end
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;    // [31:0] root, [38:32] steps_taken, [39] limit_hit
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  search_res_t pending_roots[$];
  logic [30:0] tol_shadow;
  int          n_errors;
  int          cycle_cnt;
  int          burst_left;
  int          ready_mode;

  bisection_root_finder u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // f(x) = x*x - cos(5x), Q.27 result
  function automatic longint f_of(longint x);
    longint unsigned ax;
    longint sq, t, k, z, cx, cy, dx, dy, c;
    ax = (x < 0) ? longint'(-x) : x;
    if ((ax >> 32) != 0) return 64'sd1 <<< 62;
    sq = longint'((ax * ax) >> 27);
    t  = longint'(ax * 5) <<< 3;
    k  = (t + HALF_PI_Q / 2) / HALF_PI_Q;
    z  = t - k * HALF_PI_Q;
    cx = GAIN_Q;
    cy = 0;
    for (int i = 0; i < N_STAGES; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (z >= 0) begin
        cx = cx - dx; cy = cy + dy; z = z - ATAN_TAB[i];
      end else begin
        cx = cx + dx; cy = cy - dy; z = z + ATAN_TAB[i];
      end
    end
    case (k & 3)
      0: c = cx;
      1: c = -cy;
      2: c = -cx;
      default: c = cy;
    endcase
    return sq - (c >>> 3);
  endfunction

  function automatic longint mid_of(longint a, longint b);
    return (a >>> 1) + (b >>> 1) + (a & b & 1);
  endfunction

  function automatic search_res_t bisect(logic signed [DW-1:0] lo, logic signed [DW-1:0] hi,
                                         logic [30:0] tol);
    search_res_t r;
    longint a, b, fa, m, fm;
    int steps;
    a = lo;
    b = hi;
    steps = 0;
    r.limit = 1'b0;
    if (a < b) begin
      fa = f_of(a);
      while (b - a > longint'(tol)) begin
        if (steps >= STEP_LIMIT) begin
          r.limit = 1'b1;
          break;
        end
        m  = mid_of(a, b);
        fm = f_of(m);
        if (fa == 0 || fm == 0 || ((fa < 0) != (fm < 0))) b = m;
        else begin
          a  = m;
          fa = fm;
        end
        steps++;
      end
    end
    r.root  = DW'(mid_of(a, b));
    r.steps = 7'(steps);
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $time);
    n_errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    search_res_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_roots.size() == 0) report("unexpected transaction", out_tdata[31:0], 0);
      else begin
        w = pending_roots.pop_front();
        if (out_tdata[31:0] !== w.root)
          report("root", $signed(out_tdata[31:0]), w.root);
        if (out_tdata[38:32] !== w.steps) report("steps_taken", out_tdata[38:32], w.steps);
        if (out_tdata[39] !== w.limit) report("limit_hit", out_tdata[39], w.limit);
      end
    end
  end

  // receiver stall pattern, switches character at regular intervals among four modes
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt % 3000 == 0) ready_mode <= $urandom_range(0, 3);
    case (ready_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= cycle_cnt[4];
      default: out_tready <= ($urandom_range(0, 1) != 0);
    endcase
    if (cycle_cnt > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic send_interval(logic signed [DW-1:0] lo, logic signed [DW-1:0] hi);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 15);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {hi, lo};
    do @(posedge clk); while (!in_tready);
    pending_roots.push_back(bisect(lo, hi, tol_shadow));
  endtask

  // drop valid and hold until every transaction has come back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic cfg_access(logic [2:0] addr, logic wr, logic [31:0] wdata,
                            output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_tolerance(logic [31:0] val);
    logic [31:0] rd;
    wait_idle();
    cfg_access(ADDR_TOL, 1'b1, val, rd);
    tol_shadow = val[30:0];
    cfg_access(ADDR_TOL, 1'b0, 32'd0, rd);
    if (rd[30:0] !== tol_shadow) report("tolerance readback", rd[30:0], tol_shadow);
  endtask

  task automatic test_reset_value();
    logic [31:0] rd;
    cfg_access(ADDR_TOL, 1'b0, 32'd0, rd);
    if (rd[30:0] !== TOL_RESET) report("tolerance after reset", rd[30:0], TOL_RESET);
    // a write to an unmapped register must leave the tolerance alone
    cfg_access(ADDR_SPARE, 1'b1, 32'h0000_0001, rd);
    cfg_access(ADDR_TOL, 1'b0, 32'd0, rd);
    if (rd[30:0] !== TOL_RESET) report("tolerance after spare write", rd[30:0], TOL_RESET);
  endtask

  task automatic test_directed();
    send_interval(32'sh8000_0000, 32'sh7FFF_FFFF);
    send_interval(0, ONE_Q27);
    send_interval(-ONE_Q27, 0);
    send_interval(-2 * ONE_Q27, 2 * ONE_Q27);
    send_interval(0, 0);
    send_interval(ONE_Q27, ONE_Q27);
    send_interval(ONE_Q27, -ONE_Q27);
    send_interval(32'sh7FFF_FFFF, 32'sh8000_0000);
    send_interval(32'sh8000_0000, 32'sh8000_0001);
    send_interval(32'sh7FFF_FFFE, 32'sh7FFF_FFFF);
    send_interval(32'sh8000_0000, 32'sh8000_0000);
    send_interval(3 * ONE_Q27, 15 * ONE_Q27);
    set_tolerance(32'd0);
    // width one: no progress, runs into the step limit
    send_interval(100, 101);
    send_interval(0, ONE_Q27);
    send_interval(32'sh8000_0000, 32'sh7FFF_FFFF);
    set_tolerance(32'h7FFF_FFFF);
    send_interval(32'sh8000_0000, 32'sh7FFF_FFFF);
    send_interval(0, ONE_Q27);
    set_tolerance(32'hFFFF_FFFF);
    send_interval(-ONE_Q27, ONE_Q27);
    set_tolerance(32'd1);
    send_interval(-ONE_Q27, ONE_Q27);
  endtask

  task automatic random_intervals(int count);
    logic signed [DW-1:0] lo, hi;
    int kind;
    repeat (count) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        // narrow window around the roots of f
        lo = $signed($urandom_range(0, 6 * ONE_Q27)) - 3 * ONE_Q27;
        hi = lo + $signed($urandom_range(1, 2 * ONE_Q27));
      end else if (kind < 70) begin
        lo = -$signed($urandom_range(0, 4 * ONE_Q27));
        hi = $signed($urandom_range(0, 4 * ONE_Q27));
      end else if (kind < 88) begin
        lo = $urandom;
        hi = $urandom;
      end else begin
        hi = $urandom;
        lo = (kind[0]) ? hi : hi + $signed($urandom_range(0, ONE_Q27));
      end
      send_interval(lo, hi);
    end
  endtask

  task automatic test_tolerance_sweep();
    set_tolerance(32'd1);
    random_intervals(80);
    set_tolerance(32'd0);
    random_intervals(60);
    set_tolerance(32'h7FFF_FFFF);
    random_intervals(50);
    set_tolerance($urandom_range(1, 1 << 24));
    random_intervals(80);
    set_tolerance($urandom);
    random_intervals(40);
    set_tolerance(TOL_RESET);
    random_intervals(80);
  endtask

  task automatic test_pause_until_drained();
    random_intervals(20);
    wait_idle();
    random_intervals(70);
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    n_errors    = 0;
    cycle_cnt   = 0;
    burst_left  = 0;
    ready_mode  = 0;
    tol_shadow  = TOL_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_value();
    test_directed();
    set_tolerance(TOL_RESET);
    test_pause_until_drained();
    test_tolerance_sweep();

    wait_idle();
    repeat (100) @(posedge clk);
    if (n_errors == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule
